### rtl/dcc_pkg.sv
package dcc_pkg;

  // Default sizes
  localparam int unsigned DCC_DICT_DEPTH = 4096;
  localparam int unsigned DCC_MAX_ROWS   = 2048;

  // Fixed field widths
  localparam int unsigned CODE_W      = 12;
  localparam int unsigned NEW_CODE_W  = 11;
  localparam int unsigned USED_W      = 12;
  localparam int unsigned DICT_CFG_W  = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 13;

  // Batch tag kept with each map entry; a clearing pass runs when it wraps
  localparam int unsigned EPOCH_W = 8;

  localparam logic [DICT_CFG_W-1:0] DICT_ENTRIES_RST = 13'd4096;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DICT_ENTRIES   = 1'b0,
    REG_COMPACT_ENABLE = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } dcc_state_e;

  // One map entry: batch tag and dense code
  typedef struct packed {
    logic [EPOCH_W-1:0]    epoch;
    logic [NEW_CODE_W-1:0] new_code;
  } map_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take the word, issue map read
    logic commit;     // resolve lookup, update map and counters, emit result
    logic clr_start;  // restart the clearing address
    logic clr_step;   // write one cleared entry
  } dcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing address is at the final entry
    logic wrap;       // batch ends and the batch tag runs out
  } dcc_sts_t;

endpackage

### rtl/dcc_ram.sv
module dcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dcc_ctrl.sv
module dcc_ctrl import dcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dcc_sts_t sts_i,
  output dcc_cmd_t cmd_o,
  output logic     busy_o
);

  dcc_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.commit = 1'b1;
        if (sts_i.wrap) begin
          cmd_o.clr_start = 1'b1;
          state_d         = ST_CLEAR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### rtl/dcc_dp.sv
module dcc_dp import dcc_pkg::*; #(
  parameter int unsigned DICT_DEPTH = DCC_DICT_DEPTH,
  parameter int unsigned MAX_ROWS   = DCC_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [CODE_W-1:0]     code_i,
  input  logic                  last_i,
  input  dcc_cmd_t              cmd_i,
  output dcc_sts_t              sts_o,
  output logic                  valid_o,
  output logic [NEW_CODE_W-1:0] new_code_o,
  output logic                  first_seen_o,
  output logic                  bad_code_o,
  output logic [USED_W-1:0]     used_total_o,
  output logic                  batch_done_o,
  output logic                  worth_compacting_o
);

  localparam int unsigned AW = $clog2(DICT_DEPTH);
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned MW = $bits(map_word_t);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // Configuration registers
  logic [DICT_CFG_W-1:0] dict_q;
  logic                  en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_q <= DICT_ENTRIES_RST;
      en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DICT_ENTRIES:   dict_q <= cfg_wdata_i[DICT_CFG_W-1:0];
        REG_COMPACT_ENABLE: en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input word capture
  logic [CODE_W-1:0] code_q;
  logic              last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= code_i;
      last_q <= last_i;
    end
  end

  logic [31:0]   code_in_ext;
  logic [31:0]   code_ext;
  logic [AW-1:0] raddr;
  logic [AW-1:0] caddr;

  assign code_in_ext = 32'(code_i);
  assign code_ext    = 32'(code_q);
  assign raddr       = code_in_ext[AW-1:0];
  assign caddr       = code_ext[AW-1:0];

  // Batch counters, batch tag and clearing address
  logic [CW-1:0]      used_q, used_d;
  logic [CW-1:0]      row_q, row_d;
  logic [EPOCH_W-1:0] epoch_q;
  logic [AW-1:0]      clr_q;

  // Map memory
  map_word_t rd_word;
  map_word_t wr_word;
  logic      ram_we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] rdata;

  assign rd_word = map_word_t'(rdata);

  // Lookup resolution
  logic        range_bad;
  logic        seen;
  logic        full;
  logic        bad;
  logic        is_new;
  logic [31:0] used_ext;
  logic [31:0] used_d_ext;
  logic [NEW_CODE_W-1:0] used_code;
  logic [NEW_CODE_W-1:0] new_code;
  logic        worth;

  always_comb begin
    range_bad  = (code_ext >= 32'(dict_q)) || (code_ext >= 32'(DICT_DEPTH));
    seen       = (rd_word.epoch == epoch_q);
    used_ext   = 32'(used_q);
    full       = (used_ext >= 32'(MAX_ROWS));
    bad        = range_bad || (!seen && full);
    is_new     = !range_bad && !seen && !full;
    used_code  = used_ext[NEW_CODE_W-1:0];
    if (is_new) begin
      new_code = used_code;
    end else if (!bad) begin
      new_code = rd_word.new_code;
    end else begin
      new_code = '0;
    end
    used_d     = used_q + CW'(is_new);
    used_d_ext = 32'(used_d);
    if (!bad && (32'(row_q) < 32'(MAX_ROWS))) begin
      row_d = row_q + CW'(1);
    end else begin
      row_d = row_q;
    end
    worth = last_q && en_q && ({used_d, 1'b0} < {1'b0, row_d});
  end

  // Map write: new entry on commit, tag zero while clearing
  always_comb begin
    ram_we = 1'b0;
    waddr  = caddr;
    wr_word.epoch    = epoch_q;
    wr_word.new_code = used_code;
    if (cmd_i.clr_step) begin
      ram_we  = 1'b1;
      waddr   = clr_q;
      wr_word = '0;
    end else if (cmd_i.commit && is_new) begin
      ram_we = 1'b1;
    end
  end

  dcc_ram #(
    .WIDTH (MW),
    .DEPTH (DICT_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_word),
    .re_i    (cmd_i.load),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Counter and tag updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      row_q   <= '0;
      epoch_q <= EPOCH_FIRST;
      clr_q   <= '0;
    end else begin
      if (cmd_i.commit) begin
        if (last_q) begin
          used_q  <= '0;
          row_q   <= '0;
          epoch_q <= (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
        end else begin
          used_q <= used_d;
          row_q  <= row_d;
        end
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(DICT_DEPTH - 1));
  assign sts_o.wrap     = last_q && (epoch_q == EPOCH_LAST);

  // Result register
  logic                  valid_q;
  logic [NEW_CODE_W-1:0] new_code_q;
  logic                  first_q;
  logic                  bad_q;
  logic [USED_W-1:0]     used_tot_q;
  logic                  done_q;
  logic                  worth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      new_code_q <= new_code;
      first_q    <= is_new;
      bad_q      <= bad;
      used_tot_q <= used_d_ext[USED_W-1:0];
      done_q     <= last_q;
      worth_q    <= worth;
    end
  end

  assign valid_o            = valid_q;
  assign new_code_o         = new_code_q;
  assign first_seen_o       = first_q;
  assign bad_code_o         = bad_q;
  assign used_total_o       = used_tot_q;
  assign batch_done_o       = done_q;
  assign worth_compacting_o = worth_q;

endmodule

### rtl/dictionary_code_compactor.sv
// Dense relabeling of dictionary codes in order of first appearance.
// Input: raise start_i with code_i and last_i; the word is taken at a clock
// edge where start_i is high and busy_o is low. last_i closes the batch.
// Output: one result word per input word, shown for one cycle with valid_o
// high. The receiver cannot stall; every word must be taken when valid_o is up.
// valid_o and the result word come from the result register, loaded in the
// lookup state that follows the accepting edge.
// A new word is not taken while busy_o is high: the code map is read at the
// accepting edge and written back in the lookup state, before the next word.
// The last word of a batch carries batch_done_o, used_total_o and
// worth_compacting_o, and the batch state then clears.
// Reset: a clearing pass writes every map entry with busy_o high. Each map
// entry carries an 8-bit batch tag; after 255 batches the tag wraps and
// another clearing pass runs.
// Configuration: cfg_we_i with cfg_idx_i / cfg_wdata_i, only while idle.
module dictionary_code_compactor import dcc_pkg::*; #(
  parameter int unsigned DICT_DEPTH = DCC_DICT_DEPTH,
  parameter int unsigned MAX_ROWS   = DCC_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [CODE_W-1:0]     code_i,
  input  logic                  last_i,
  output logic                  valid_o,
  output logic [NEW_CODE_W-1:0] new_code_o,
  output logic                  first_seen_o,
  output logic                  bad_code_o,
  output logic [USED_W-1:0]     used_total_o,
  output logic                  batch_done_o,
  output logic                  worth_compacting_o
);

  dcc_cmd_t cmd;
  dcc_sts_t sts;

  dcc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  dcc_dp #(
    .DICT_DEPTH (DICT_DEPTH),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .code_i             (code_i),
    .last_i             (last_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .valid_o            (valid_o),
    .new_code_o         (new_code_o),
    .first_seen_o       (first_seen_o),
    .bad_code_o         (bad_code_o),
    .used_total_o       (used_total_o),
    .batch_done_o       (batch_done_o),
    .worth_compacting_o (worth_compacting_o)
  );

endmodule

### rtl/dcc_checker.sv
module dcc_checker import dcc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  valid_o,
  input logic [NEW_CODE_W-1:0] new_code_o,
  input logic                  first_seen_o,
  input logic                  bad_code_o,
  input logic [USED_W-1:0]     used_total_o
);

  // An accepted word makes the block busy for its lookup
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepting a word");

  // Each accepted word yields a result through the lookup state and the result register
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 valid_o)
    else $error("result missing two cycles after accept");

  // A result follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result word without preceding lookup");

  // A rejected code gives a zero code and no first sighting
  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && bad_code_o) |-> (!first_seen_o && new_code_o == '0))
    else $error("rejected code word carries a code");

  // A first sighting counts toward the used total
  a_first_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && first_seen_o) |-> (used_total_o != '0))
    else $error("first sighting with zero used total");

endmodule

bind dictionary_code_compactor dcc_checker u_dcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .valid_o      (valid_o),
  .new_code_o   (new_code_o),
  .first_seen_o (first_seen_o),
  .bad_code_o   (bad_code_o),
  .used_total_o (used_total_o)
);

### tb/dictionary_code_compactor_test.sv
`timescale 1ns / 100ps

module dictionary_code_compactor_test;
  import dcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  // Expected contents of one result word
  typedef struct packed {
    logic [NEW_CODE_W-1:0] new_code;
    logic                  first_seen;
    logic                  bad_code;
    logic [USED_W-1:0]     used_total;
    logic                  batch_done;
    logic                  worth;
  } relabel_word_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_DICT_ENTRIES;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start_i     = 1'b0;
  logic [CODE_W-1:0]     code_i      = '0;
  logic                  last_i      = 1'b0;
  logic                  busy_o;
  logic                  valid_o;
  logic [NEW_CODE_W-1:0] new_code_o;
  logic                  first_seen_o;
  logic                  bad_code_o;
  logic [USED_W-1:0]     used_total_o;
  logic                  batch_done_o;
  logic                  worth_compacting_o;

  dictionary_code_compactor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .code_i             (code_i),
    .last_i             (last_i),
    .valid_o            (valid_o),
    .new_code_o         (new_code_o),
    .first_seen_o       (first_seen_o),
    .bad_code_o         (bad_code_o),
    .used_total_o       (used_total_o),
    .batch_done_o       (batch_done_o),
    .worth_compacting_o (worth_compacting_o)
  );

  always #6 clk_i = ~clk_i;

  // Relabeling state of the predictor
  bit                    seen_q    [DCC_DICT_DEPTH];
  logic [NEW_CODE_W-1:0] dense_map [DCC_DICT_DEPTH];
  int unsigned           used_cnt;
  int unsigned           row_cnt;
  int unsigned           dict_size;
  logic                  compact_on;

  relabel_word_t expected_labels[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles     = 0;
  bit            gaps_on    = 1'b1;

  function automatic void clear_batch_state();
    foreach (seen_q[i]) seen_q[i] = 1'b0;
    used_cnt = 0;
    row_cnt  = 0;
  endfunction

  // Renumber one code and update the batch state
  function automatic relabel_word_t relabel_code(input logic [CODE_W-1:0] code,
                                                 input logic is_last);
    relabel_word_t w;
    w = '0;
    if (code >= dict_size || code >= DCC_DICT_DEPTH) begin
      w.bad_code = 1'b1;
    end else if (seen_q[code]) begin
      w.new_code = dense_map[code];
    end else if (used_cnt >= DCC_MAX_ROWS) begin
      w.bad_code = 1'b1;
    end else begin
      w.new_code      = used_cnt[NEW_CODE_W-1:0];
      dense_map[code] = used_cnt[NEW_CODE_W-1:0];
      seen_q[code]    = 1'b1;
      used_cnt++;
      w.first_seen    = 1'b1;
    end
    if (!w.bad_code && row_cnt < DCC_MAX_ROWS) row_cnt++;
    w.worth      = is_last && compact_on && (2 * used_cnt < row_cnt);
    w.used_total = used_cnt[USED_W-1:0];
    w.batch_done = is_last;
    if (is_last) clear_batch_state();
    return w;
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[dictionary_code_compactor] ERROR");
      $finish;
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker: each word against the oldest expectation
  always @(posedge clk_i) begin
    relabel_word_t w;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_labels.size() == 0) begin
        $display("%0t: unexpected word, actual new_code %0d", $time, new_code_o);
        mismatches++;
      end else begin
        w = expected_labels.pop_front();
        check_field("new_code", w.new_code, new_code_o);
        check_field("first_seen", w.first_seen, first_seen_o);
        check_field("bad_code", w.bad_code, bad_code_o);
        check_field("used_total", w.used_total, used_total_o);
        check_field("batch_done", w.batch_done, batch_done_o);
        check_field("worth_compacting", w.worth, worth_compacting_o);
      end
    end
  end

  // Send one word; start_i stays high afterwards until the next gap or drain
  task automatic send_code(input logic [CODE_W-1:0] code, input logic is_last);
    if (gaps_on) begin
      while ($urandom_range(99) < 29) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    code_i  <= code;
    last_i  <= is_last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_labels.push_back(relabel_code(code, is_last));
  endtask

  // Stop sending and wait until the block is idle
  task automatic drain_words();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_labels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Wait for idle, then write both registers back to back
  task automatic set_config(input int unsigned dict_val, input logic enable);
    drain_words();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DICT_ENTRIES;
    cfg_wdata_i <= dict_val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx_i   <= REG_COMPACT_ENABLE;
    cfg_wdata_i <= {{(CFG_DATA_W-1){1'b0}}, enable};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dict_size  = dict_val[CFG_DATA_W-1:0];
    compact_on = enable;
  endtask

  // Reset defaults, extreme codes, repeats
  task automatic test_defaults();
    send_code(12'd0, 1'b0);
    send_code(12'd4095, 1'b0);
    send_code(12'd0, 1'b0);
    send_code(12'd4095, 1'b0);
    send_code(12'd7, 1'b1);
    drain_words();
  endtask

  // Payoff flag with compaction on and off
  task automatic test_payoff();
    repeat (3) send_code(12'd5, 1'b0);
    send_code(12'd5, 1'b1);
    set_config(4096, 1'b0);
    repeat (3) send_code(12'd5, 1'b0);
    send_code(12'd5, 1'b1);
    drain_words();
  endtask

  // Out-of-range codes, empty batch, bad final row, size zero and oversize
  task automatic test_bad_codes();
    set_config(1, 1'b1);
    send_code(12'd0, 1'b0);
    send_code(12'd1, 1'b0);
    send_code(12'd0, 1'b0);
    send_code(12'd4095, 1'b1);
    send_code(12'd3, 1'b1);
    drain_words();
    set_config(0, 1'b1);
    send_code(12'd0, 1'b0);
    send_code(12'd0, 1'b1);
    drain_words();
    set_config(8191, 1'b1);
    send_code(12'd4095, 1'b0);
    send_code(12'd4095, 1'b1);
    drain_words();
  endtask

  // Full map of distinct codes, rejected new codes, saturated row count
  task automatic test_capacity_limits();
    set_config(4096, 1'b1);
    for (int i = 0; i < DCC_MAX_ROWS; i++) send_code(12'(4095 - i), 1'b0);
    for (int i = 0; i < 6; i++) send_code(12'(i), 1'b0);
    for (int i = 0; i < 40; i++) send_code(12'(2048 + $urandom_range(2047)), 1'b0);
    send_code(12'd4095, 1'b1);
    drain_words();
  endtask

  // One batch of codes clustered around a random base, mostly repeats
  task automatic send_batch(input int unsigned len, input int unsigned max_code);
    int unsigned base;
    int unsigned span;
    logic [CODE_W-1:0] code;
    base = $urandom_range(max_code);
    if ($urandom_range(3) == 0) base = (dict_size > 4) ? dict_size - 4 : 0;
    span = $urandom_range(15);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 80) code = 12'(base + $urandom_range(span));
      else code = 12'($urandom_range(max_code));
      send_code(code, i == len - 1);
    end
  endtask

  // Random batches over several dictionary sizes
  task automatic test_random_batches();
    int unsigned dicts[6] = '{16, 4096, 1, 8191, 0, 2};
    int unsigned dict_val;
    int unsigned sent;
    int unsigned len;
    logic        enable;
    for (int p = 0; p < 6; p++) begin
      dict_val = (p == 4) ? $urandom_range(1, 4096) : dicts[p];
      enable   = (p == 1) ? 1'b0 : ((p == 4) ? 1'($urandom_range(1)) : 1'b1);
      set_config(dict_val, enable);
      gaps_on = (p != 3);
      sent = 0;
      while (sent < 75) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
        send_batch(len, 4095);
        sent += len;
      end
      drain_words();
    end
    gaps_on = 1'b1;
  endtask

  // Many short batches so the batch tag wraps and the map is cleared again
  task automatic test_tag_wrap();
    set_config(64, 1'b1);
    for (int b = 0; b < 270; b++) begin
      send_batch($urandom_range(1, 3), 70);
    end
    drain_words();
  endtask

  initial begin
    foreach (dense_map[i]) dense_map[i] = '0;
    clear_batch_state();
    dict_size  = 4096;
    compact_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_payoff();
    test_bad_codes();
    test_capacity_limits();
    test_random_batches();
    test_tag_wrap();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_labels.size() == 0) begin
      $display("[dictionary_code_compactor] OK");
    end else begin
      $display("[dictionary_code_compactor] ERROR");
    end
    $finish;
  end

endmodule
